// ----- src/fupd_pkg.sv -----
package fupd_pkg;

  localparam int unsigned DataW    = 8;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned QDepth   = 4;
  localparam int unsigned QPtrW    = $clog2(QDepth);
  localparam int unsigned QCntW    = $clog2(QDepth + 1);

  // register index taken from the word address
  localparam logic REG_PLUS_KEPT = 1'b0;

  localparam logic [DataW-1:0] CH_PCT   = 8'h25;
  localparam logic [DataW-1:0] CH_PLUS  = 8'h2B;
  localparam logic [DataW-1:0] CH_MINUS = 8'h2D;
  localparam logic [DataW-1:0] CH_SPACE = 8'h20;
  localparam logic [DataW-1:0] CH_CR    = 8'h0D;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_PCT   = 3'b010,
    PH_FIRST = 3'b100
  } phase_t;

  typedef struct packed {
    logic             run_last;
    logic             end_mark;
    logic [DataW-1:0] data;
  } res_t;

  typedef struct packed {
    logic             keep;
    logic [DataW-1:0] value;
  } esc_t;

  function automatic logic is_space(input logic [DataW-1:0] c);
    return (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  // {valid, nibble}
  function automatic logic [4:0] hex_value(input logic [DataW-1:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  // n escape bytes (0..2) parsed like a base-16 strtol
  function automatic esc_t decode_escape(input logic [DataW-1:0] c0,
                                         input logic [DataW-1:0] c1,
                                         input logic [1:0]       n);
    logic             p0;
    logic             p1;
    logic [4:0]       h0;
    logic [4:0]       h1;
    logic             neg;
    logic [DataW-1:0] v;
    esc_t             r;
    p0  = (n != 2'd0);
    p1  = (n == 2'd2);
    h0  = hex_value(c0);
    h1  = hex_value(c1);
    neg = 1'b0;
    v   = '0;
    if (!p0) begin
      v = '0;
    end else if (is_space(c0)) begin
      v = (p1 && h1[4]) ? {4'd0, h1[3:0]} : '0;
    end else if (c0 == CH_PLUS || c0 == CH_MINUS) begin
      neg = (c0 == CH_MINUS);
      v   = (p1 && h1[4]) ? {4'd0, h1[3:0]} : '0;
    end else if (h0[4]) begin
      v = (p1 && h1[4]) ? {h0[3:0], h1[3:0]} : {4'd0, h0[3:0]};
    end
    r.keep  = neg || (v != CH_CR);
    r.value = neg ? (8'h00 - v) : v;
    return r;
  endfunction

endpackage

// ----- src/form_url_percent_decoder.sv -----
// form-urlencoded percent decoder
// in channel: one encoded byte per request in in_tdata; in_tuser high marks
//   the terminator request, which carries no byte
// out channel: decoded bytes; out_tuser marks the end marker (data 0),
//   out_tlast marks the last result caused by one input request
// cfg: apb register 0 (byte address 0), bit 0 = plus_kept
// each input request is decoded in the cycle it is accepted and its results
//   go into a four-entry result queue, from which the out channel presents
//   them in order
// throughput: one input request per cycle while in_tready is high and one
//   result per cycle while out_tready is high; a terminator that closes an
//   open escape yields two results, unless the escape decodes to a carriage return
// in_tready is high while the queue holds at most two results, so input
//   keeps flowing while a result waits on a stalled receiver; once three or
//   more results wait on a stalled receiver the input is held off
// reset clears the escape state, empties the queue and sets plus_kept to 0
module form_url_percent_decoder (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [fupd_pkg::DataW-1:0]    in_tdata,   // in_byte
  input  logic                          in_tuser,   // in_terminator
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [fupd_pkg::DataW-1:0]    out_tdata,  // out_byte
  output logic                          out_tuser,  // out_end
  output logic                          out_tlast,  // out_run_last
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [fupd_pkg::CfgAddrW-1:0] cfg_paddr,
  input  logic [fupd_pkg::CfgDataW-1:0] cfg_pwdata,
  output logic [fupd_pkg::CfgDataW-1:0] cfg_prdata,
  output logic                          cfg_pready
);

  logic                        plus_kept_r;
  fupd_pkg::phase_t            phase_r, phase_nxt;
  logic [fupd_pkg::DataW-1:0]  first_r, first_nxt;
  fupd_pkg::res_t              q_r [fupd_pkg::QDepth];
  logic [fupd_pkg::QPtrW-1:0]  wp_r, rp_r;
  logic [fupd_pkg::QCntW-1:0]  cnt_r, cnt_nxt;
  fupd_pkg::res_t              res0, res1;
  logic [1:0]                  nres;
  fupd_pkg::esc_t              esc;
  logic                        accept;
  logic                        pop;
  logic                        cfg_hit;

  assign cfg_pready = 1'b1;
  assign cfg_hit    = (cfg_paddr[fupd_pkg::CfgAddrW-1] == fupd_pkg::REG_PLUS_KEPT);
  assign cfg_prdata = {{(fupd_pkg::CfgDataW-1){1'b0}}, cfg_hit & plus_kept_r};

  assign in_tready  = (cnt_r < fupd_pkg::QCntW'(fupd_pkg::QDepth - 1));
  assign accept     = in_tvalid & in_tready;
  assign out_tvalid = (cnt_r != '0);
  assign pop        = out_tvalid & out_tready;
  assign out_tdata  = q_r[rp_r].data;
  assign out_tuser  = q_r[rp_r].end_mark;
  assign out_tlast  = q_r[rp_r].run_last;

  always_comb begin
    phase_nxt = phase_r;
    first_nxt = first_r;
    res0      = '0;
    res1      = '0;
    nres      = 2'd0;
    esc       = fupd_pkg::decode_escape(first_r, in_tdata, 2'd2);
    if (in_tuser) begin
      phase_nxt     = fupd_pkg::PH_IDLE;
      res1.end_mark = 1'b1;
      res1.run_last = 1'b1;
      unique case (phase_r)
        fupd_pkg::PH_PCT:   esc = fupd_pkg::decode_escape(first_r, in_tdata, 2'd0);
        fupd_pkg::PH_FIRST: esc = fupd_pkg::decode_escape(first_r, in_tdata, 2'd1);
        default:            esc = '0;
      endcase
      if (esc.keep) begin
        res0.data = esc.value;
        nres      = 2'd2;
      end else begin
        res0 = res1;
        nres = 2'd1;
      end
    end else begin
      unique case (phase_r)
        fupd_pkg::PH_PCT: begin
          first_nxt = in_tdata;
          phase_nxt = fupd_pkg::PH_FIRST;
        end
        fupd_pkg::PH_FIRST: begin
          phase_nxt     = fupd_pkg::PH_IDLE;
          res0.data     = esc.value;
          res0.run_last = 1'b1;
          nres          = esc.keep ? 2'd1 : 2'd0;
        end
        default: begin
          phase_nxt     = fupd_pkg::PH_IDLE;
          res0.run_last = 1'b1;
          if (in_tdata == fupd_pkg::CH_PCT) begin
            phase_nxt = fupd_pkg::PH_PCT;
          end else begin
            res0.data = (in_tdata == fupd_pkg::CH_PLUS && !plus_kept_r) ?
                        fupd_pkg::CH_SPACE : in_tdata;
            nres      = 2'd1;
          end
        end
      endcase
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (accept) begin
      cnt_nxt = cnt_nxt + fupd_pkg::QCntW'(nres);
    end
    if (pop) begin
      cnt_nxt = cnt_nxt - fupd_pkg::QCntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plus_kept_r <= 1'b0;
      phase_r     <= fupd_pkg::PH_IDLE;
      first_r     <= '0;
      wp_r        <= '0;
      rp_r        <= '0;
      cnt_r       <= '0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_hit) begin
        plus_kept_r <= cfg_pwdata[0];
      end
      if (accept) begin
        phase_r <= phase_nxt;
        first_r <= first_nxt;
        wp_r    <= wp_r + fupd_pkg::QPtrW'(nres);
      end
      if (pop) begin
        rp_r <= rp_r + fupd_pkg::QPtrW'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && nres != 2'd0) begin
      q_r[wp_r] <= res0;
    end
    if (accept && nres == 2'd2) begin
      q_r[wp_r + fupd_pkg::QPtrW'(1)] <= res1;
    end
  end

endmodule

// ----- src/fupd_checker.sv -----
module fupd_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tvalid,
  input logic                          in_tready,
  input logic [fupd_pkg::DataW-1:0]    in_tdata,
  input logic                          in_tuser,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [fupd_pkg::DataW-1:0]    out_tdata,
  input logic                          out_tuser,
  input logic                          out_tlast
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  // end marker carries zero and closes its run
  a_end_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && out_tdata == '0)
    else $error("malformed end marker");

  // empty result queue never blocks input
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input blocked with no pending result");

  // reset empties the result queue
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

endmodule

bind form_url_percent_decoder fupd_checker u_fupd_checker (.*);
